// ===== hdl/mca_pkg.sv =====
// Shared types and constants for the mouse click aggregator.
package mca_pkg;

    localparam logic [7:0]  DC_MAX     = 8'd200;
    localparam logic [15:0] DC_EXTEND  = 16'd10;
    localparam logic [2:0]  DIV_RELOAD = 3'd2;
    localparam logic [2:0]  DIV_RESET  = 3'd4;

    typedef enum logic {
        ACT_BUTTON = 1'b0,
        ACT_TICK   = 1'b1
    } action_t;

    // One classified request handed from the front to the back.
    typedef struct packed {
        action_t            action;
        logic [7:0]         buttons;
        logic [15:0]        stamp;
        logic signed [15:0] event_x;
        logic signed [15:0] event_y;
        logic signed [15:0] now_x;
        logic signed [15:0] now_y;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] press_x;
        logic signed [15:0] press_y;
        logic signed [15:0] cur_x;
        logic signed [15:0] cur_y;
        logic [7:0]         merged_state;
        logic [7:0]         final_state;
        logic [7:0]         total_clicks;
        logic [7:0]         left_count;
        logic [7:0]         right_count;
        logic               last;
    } res_t;

endpackage

// ===== hdl/mca_ifs.sv =====
// Handshake interfaces for the input and result channels.
interface mca_item_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [7:0]         buttons;
    logic [15:0]        stamp;
    logic signed [15:0] event_x;
    logic signed [15:0] event_y;
    logic signed [15:0] now_x;
    logic signed [15:0] now_y;

    modport source (output valid, action, buttons, stamp, event_x, event_y, now_x, now_y,
                    input ready);
    modport sink (input valid, action, buttons, stamp, event_x, event_y, now_x, now_y,
                  output ready);
endinterface

interface mca_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] press_x;
    logic signed [15:0] press_y;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic [7:0]         merged_state;
    logic [7:0]         final_state;
    logic [7:0]         total_clicks;
    logic [7:0]         left_count;
    logic [7:0]         right_count;
    logic               last;

    modport source (output valid, press_x, press_y, cur_x, cur_y, merged_state, final_state,
                    total_clicks, left_count, right_count, last,
                    input ready);
    modport sink (input valid, press_x, press_y, cur_x, cur_y, merged_state, final_state,
                  total_clicks, left_count, right_count, last,
                  output ready);
endinterface

// ===== hdl/mouse_click_aggregator_core.sv =====
// Top level of the mouse click aggregator: front end, request queue, back end.
//
//  channel  | dir | handshake          | contents
//  item     | in  | valid/ready        | action, buttons, stamp, event/now position
//  result   | out | valid/ready        | click packet, last marks final result of a request
//  cfg      | in  | cfg_wr_en, no wait | double_click_time, clamped at 200
//
// One request is accepted per cycle while the queue has room (QUEUE_DEPTH entries).
// The back end retires one queued request per cycle while the result register can take a
// packet and no packet is pending; a request that emits two packets holds it until the
// second leaves the pending slot for the single result register. A request is written
// into the queue, and its result is registered when the back end pops it. Reset clears
// control state at once (divider loads 4), not queue or result data; no clearing pass.
module mouse_click_aggregator_core
    import mca_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    mca_item_if.sink     item,
    mca_result_if.source result
);

    logic   q_push;
    cmd_t   push_cmd;
    cmd_t   head_cmd;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    mca_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .q_push     (q_push),
        .q_full     (q_full),
        .push_cmd   (push_cmd)
    );

    mca_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_cmd  (head_cmd)
    );

    mca_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .result      (result)
    );

endmodule

// ===== hdl/mca_front.sv =====
// Front end: accepts requests, thins ticks through the divider, queues the rest.
module mca_front
    import mca_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mca_item_if.sink     item,
    output logic         q_push,
    input  logic         q_full,
    output cmd_t         push_cmd
);

    logic [2:0] div_reg;
    logic [2:0] div_next;
    logic [2:0] div_dec;
    logic       accept;
    logic       is_tick;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;
    assign is_tick    = (action_t'(item.action) == ACT_TICK);
    assign div_dec    = div_reg - 3'd1;

    always_comb
    begin
        div_next = div_reg;
        if (accept && is_tick)
        begin
            div_next = (div_dec == 3'd0) ? DIV_RELOAD : div_dec;
        end
    end

    // After reset the fourth tick reaches the back end, and from then on every second tick.
    assign q_push = accept && (!is_tick || (div_dec == 3'd0));

    assign push_cmd.action  = action_t'(item.action);
    assign push_cmd.buttons = item.buttons;
    assign push_cmd.stamp   = item.stamp;
    assign push_cmd.event_x = item.event_x;
    assign push_cmd.event_y = item.event_y;
    assign push_cmd.now_x   = item.now_x;
    assign push_cmd.now_y   = item.now_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg <= DIV_RESET;
        end
        else
        begin
            div_reg <= div_next;
        end
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_reg != 3'd0)
        else $error("tick divider at zero");
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");
`endif

endmodule

// ===== hdl/mca_queue.sv =====
// Short request queue between front and back.
module mca_queue
    import mca_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  cmd_t  push_cmd,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output cmd_t  head_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

// ===== hdl/mca_back.sv =====
// Back end: click packet state, countdown, and the result register with a pending slot.
module mca_back
    import mca_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    input  logic         q_valid,
    input  cmd_t         q_cmd,
    output logic         q_pop,
    mca_result_if.source result
);

    logic [7:0]         dct_reg;
    logic [7:0]         prev_buttons_reg, prev_buttons_next;
    logic [15:0]        prev_stamp_reg, prev_stamp_next;
    logic [15:0]        time_left_reg, time_left_next;
    logic signed [15:0] held_x_reg, held_x_next;
    logic signed [15:0] held_y_reg, held_y_next;
    logic [7:0]         held_merged_reg, held_merged_next;
    logic [7:0]         held_final_reg, held_final_next;
    logic [7:0]         click_total_reg, click_total_next;
    logic [7:0]         left_total_reg, left_total_next;
    logic [7:0]         right_total_reg, right_total_next;

    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;
    logic               pend_valid_reg, pend_valid_next;
    res_t               pend_reg, pend_next;

    logic               out_free;
    logic               checking;
    logic               expired;
    logic               changed;
    logic               release_emit;
    logic [15:0]        dt;
    logic [15:0]        tl_dec;
    logic [15:0]        tl_mid;
    logic [8:0]         click_sum;
    logic [7:0]         click_sat;
    res_t               res_expire;
    res_t               res_release;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    assign out_free = !out_valid_reg || result.ready;
    assign q_pop    = !pend_valid_reg && q_valid && out_free;

    // Countdown update common to events and acting ticks
    assign checking = (time_left_reg != 16'd0);
    assign dt       = q_cmd.stamp - prev_stamp_reg;
    assign tl_dec   = time_left_reg - dt;
    assign expired  = checking && ((tl_dec == 16'd0) || tl_dec[15]);
    assign tl_mid   = !checking ? time_left_reg : (expired ? 16'd0 : tl_dec);

    assign changed      = (q_cmd.action == ACT_BUTTON) && (q_cmd.buttons != prev_buttons_reg);
    assign release_emit = changed && (tl_mid == 16'd0) && (q_cmd.buttons[1:0] == 2'b00);

    assign click_sum = {1'b0, click_total_reg} + {8'd0, q_cmd.buttons[0]}
                     + {8'd0, q_cmd.buttons[1]};
    assign click_sat = click_sum[8] ? 8'hFF : click_sum[7:0];

    always_comb
    begin
        res_expire.press_x      = held_x_reg;
        res_expire.press_y      = held_y_reg;
        res_expire.cur_x        = q_cmd.now_x;
        res_expire.cur_y        = q_cmd.now_y;
        res_expire.merged_state = held_merged_reg;
        res_expire.final_state  = held_final_reg;
        res_expire.total_clicks = click_total_reg;
        res_expire.left_count   = left_total_reg;
        res_expire.right_count  = right_total_reg;
        res_expire.last         = !release_emit;

        // release opening an empty packet: counts cleared, position from the event
        res_release.press_x      = q_cmd.event_x;
        res_release.press_y      = q_cmd.event_y;
        res_release.cur_x        = q_cmd.now_x;
        res_release.cur_y        = q_cmd.now_y;
        res_release.merged_state = q_cmd.buttons;
        res_release.final_state  = q_cmd.buttons;
        res_release.total_clicks = 8'd0;
        res_release.left_count   = 8'd0;
        res_release.right_count  = 8'd0;
        res_release.last         = 1'b1;
    end

    always_comb
    begin
        prev_buttons_next = prev_buttons_reg;
        prev_stamp_next   = prev_stamp_reg;
        time_left_next    = time_left_reg;
        held_x_next       = held_x_reg;
        held_y_next       = held_y_reg;
        held_merged_next  = held_merged_reg;
        held_final_next   = held_final_reg;
        click_total_next  = click_total_reg;
        left_total_next   = left_total_reg;
        right_total_next  = right_total_reg;

        if (q_pop)
        begin
            if (checking)
            begin
                prev_stamp_next = q_cmd.stamp;
            end
            time_left_next = tl_mid;
            if (changed)
            begin
                prev_buttons_next = q_cmd.buttons;
                held_final_next   = q_cmd.buttons;
                if (tl_mid != 16'd0)
                begin
                    held_merged_next = held_merged_reg | q_cmd.buttons;
                    click_total_next = click_sat;
                    if (q_cmd.buttons[0])
                    begin
                        left_total_next = sat_inc(left_total_reg);
                    end
                    if (q_cmd.buttons[1])
                    begin
                        right_total_next = sat_inc(right_total_reg);
                    end
                    if (click_sat > 8'd1)
                    begin
                        time_left_next = tl_mid + DC_EXTEND;
                    end
                end
                else
                begin
                    held_merged_next = q_cmd.buttons;
                    held_x_next      = q_cmd.event_x;
                    held_y_next      = q_cmd.event_y;
                    if (q_cmd.buttons[1:0] != 2'b00)
                    begin
                        prev_stamp_next  = q_cmd.stamp;
                        time_left_next   = {8'd0, dct_reg};
                        click_total_next = 8'd1;
                        left_total_next  = {7'd0, q_cmd.buttons[0]};
                        right_total_next = {7'd0, q_cmd.buttons[1]};
                    end
                    else
                    begin
                        click_total_next = 8'd0;
                        left_total_next  = 8'd0;
                        right_total_next = 8'd0;
                        time_left_next   = 16'd0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (out_free)
        begin
            priority if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (q_pop && (expired || release_emit))
            begin
                out_next        = expired ? res_expire : res_release;
                out_valid_next  = 1'b1;
                pend_valid_next = expired && release_emit;
                pend_next       = res_release;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.press_x      = out_reg.press_x;
    assign result.press_y      = out_reg.press_y;
    assign result.cur_x        = out_reg.cur_x;
    assign result.cur_y        = out_reg.cur_y;
    assign result.merged_state = out_reg.merged_state;
    assign result.final_state  = out_reg.final_state;
    assign result.total_clicks = out_reg.total_clicks;
    assign result.left_count   = out_reg.left_count;
    assign result.right_count  = out_reg.right_count;
    assign result.last         = out_reg.last;

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dct_reg          <= 8'd0;
            prev_buttons_reg <= 8'd0;
            prev_stamp_reg   <= 16'd0;
            time_left_reg    <= 16'd0;
            held_x_reg       <= 16'sd0;
            held_y_reg       <= 16'sd0;
            held_merged_reg  <= 8'd0;
            held_final_reg   <= 8'd0;
            click_total_reg  <= 8'd0;
            left_total_reg   <= 8'd0;
            right_total_reg  <= 8'd0;
            out_valid_reg    <= 1'b0;
            pend_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dct_reg <= (cfg_wr_data > DC_MAX) ? DC_MAX : cfg_wr_data;
            end
            prev_buttons_reg <= prev_buttons_next;
            prev_stamp_reg   <= prev_stamp_next;
            time_left_reg    <= time_left_next;
            held_x_reg       <= held_x_next;
            held_y_reg       <= held_y_next;
            held_merged_reg  <= held_merged_next;
            held_final_reg   <= held_final_next;
            click_total_reg  <= click_total_next;
            left_total_reg   <= left_total_next;
            right_total_reg  <= right_total_next;
            out_valid_reg    <= out_valid_next;
            pend_valid_reg   <= pend_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending result without a result in the output register");
    a_not_last_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last) |-> pend_valid_reg)
        else $error("non-final result with nothing pending");
    a_dct_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        dct_reg <= DC_MAX)
        else $error("double click time above limit");
`endif

endmodule

// ===== tb/click_packet_checker.sv =====
// Checker: watches the request and packet channels, predicts click packets and compares them.
module click_packet_checker
    import mca_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    mca_item_if          item_mon,
    mca_result_if        res_mon,
    output int           fail_cnt,
    output int           pending_cnt,
    output int           packet_cnt
);

    logic [7:0]  window;
    logic [7:0]  last_buttons;
    logic [15:0] last_stamp;
    logic [15:0] countdown;
    logic [15:0] anchor_x;
    logic [15:0] anchor_y;
    logic [7:0]  or_state;
    logic [7:0]  new_state;
    logic [7:0]  clicks;
    logic [7:0]  lefts;
    logic [7:0]  rights;
    logic [2:0]  tick_phase;
    res_t        packets_due[$];
    int          errs;
    int          seen;

    function automatic logic [7:0] bump(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // Builds the packet from the held state and disarms the countdown.
    function automatic res_t close_packet(input logic [15:0] cx, input logic [15:0] cy);
        res_t p;
        p.press_x      = anchor_x;
        p.press_y      = anchor_y;
        p.cur_x        = cx;
        p.cur_y        = cy;
        p.merged_state = or_state;
        p.final_state  = new_state;
        p.total_clicks = clicks;
        p.left_count   = lefts;
        p.right_count  = rights;
        p.last         = 1'b0;
        countdown      = 16'd0;
        return p;
    endfunction

    // Moves the countdown to the given stamp; flags expiry (zero or negative).
    task automatic advance(input logic [15:0] st, output logic gone);
        logic [15:0] dt;
        dt         = st - last_stamp;
        last_stamp = st;
        countdown  = countdown - dt;
        gone       = (countdown == 16'd0) || countdown[15];
    endtask

    task automatic predict_clicks(input cmd_t c);
        res_t outs[2];
        int   n;
        logic gone;
        n    = 0;
        gone = 1'b0;
        if (c.action == ACT_TICK)
        begin
            tick_phase = tick_phase - 3'd1;
            if (tick_phase == 3'd0)
            begin
                tick_phase = DIV_RELOAD;
                if (countdown != 16'd0)
                    advance(c.stamp, gone);
                if (gone)
                begin
                    outs[n] = close_packet(c.now_x, c.now_y);
                    n++;
                end
            end
        end
        else
        begin
            if (countdown != 16'd0)
                advance(c.stamp, gone);
            if (gone)
            begin
                outs[n] = close_packet(c.now_x, c.now_y);
                n++;
            end
            if (c.buttons != last_buttons)
            begin
                last_buttons = c.buttons;
                if (countdown != 16'd0)
                begin
                    or_state  = or_state | c.buttons;
                    new_state = c.buttons;
                    if (c.buttons[0])
                    begin
                        lefts  = bump(lefts);
                        clicks = bump(clicks);
                    end
                    if (c.buttons[1])
                    begin
                        rights = bump(rights);
                        clicks = bump(clicks);
                    end
                    if (clicks > 8'd1)
                        countdown = countdown + DC_EXTEND;
                end
                else
                begin
                    or_state  = c.buttons;
                    new_state = c.buttons;
                    anchor_x  = c.event_x;
                    anchor_y  = c.event_y;
                    if (c.buttons[1:0] != 2'b00)
                    begin
                        last_stamp = c.stamp;
                        countdown  = {8'd0, window};
                        clicks     = 8'd1;
                        lefts      = {7'd0, c.buttons[0]};
                        rights     = {7'd0, c.buttons[1]};
                    end
                    else
                    begin
                        // opened with nothing pressed: goes out at once
                        clicks  = 8'd0;
                        lefts   = 8'd0;
                        rights  = 8'd0;
                        outs[n] = close_packet(c.now_x, c.now_y);
                        n++;
                    end
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            outs[i].last = (i == n - 1);
            packets_due.push_back(outs[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%04h, got 0x%04h", name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        cmd_t c;
        if (!rst_n)
        begin
            window       = 8'd0;
            last_buttons = 8'd0;
            last_stamp   = 16'd0;
            countdown    = 16'd0;
            anchor_x     = 16'd0;
            anchor_y     = 16'd0;
            or_state     = 8'd0;
            new_state    = 8'd0;
            clicks       = 8'd0;
            lefts        = 8'd0;
            rights       = 8'd0;
            tick_phase   = DIV_RESET;
            packets_due.delete();
            errs         = 0;
            seen         = 0;
            fail_cnt    <= 0;
            pending_cnt <= 0;
            packet_cnt  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                window = (cfg_wr_data > DC_MAX) ? DC_MAX : cfg_wr_data;
            // a packet accepted now comes from an earlier request, so compare first
            if (res_mon.valid && res_mon.ready)
            begin
                seen++;
                if (packets_due.size() == 0)
                begin
                    $error("click packet with none expected");
                    errs++;
                end
                else
                begin
                    want = packets_due.pop_front();
                    check_field("press_x", want.press_x, res_mon.press_x);
                    check_field("press_y", want.press_y, res_mon.press_y);
                    check_field("cur_x", want.cur_x, res_mon.cur_x);
                    check_field("cur_y", want.cur_y, res_mon.cur_y);
                    check_field("merged_state", want.merged_state, res_mon.merged_state);
                    check_field("final_state", want.final_state, res_mon.final_state);
                    check_field("total_clicks", want.total_clicks, res_mon.total_clicks);
                    check_field("left_count", want.left_count, res_mon.left_count);
                    check_field("right_count", want.right_count, res_mon.right_count);
                    check_field("last", want.last, res_mon.last);
                end
            end
            if (item_mon.valid && item_mon.ready)
            begin
                c.action  = action_t'(item_mon.action);
                c.buttons = item_mon.buttons;
                c.stamp   = item_mon.stamp;
                c.event_x = item_mon.event_x;
                c.event_y = item_mon.event_y;
                c.now_x   = item_mon.now_x;
                c.now_y   = item_mon.now_y;
                predict_clicks(c);
            end
            fail_cnt    <= errs;
            pending_cnt <= packets_due.size();
            packet_cnt  <= seen;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, request stimulus, window settings, packet back-pressure, verdict.
module tb_top;
    import mca_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASES         = 8;
    localparam int PHASE_REQUESTS = 140;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          chk_fails;
    int          chk_pending;
    int          chk_packets;
    int          sent = 0;
    int          idle_run = 0;
    logic [15:0] clock_now;
    logic [7:0]  held_btn;
    cmd_t        script[$];

    int phase_window[PHASES] = '{200, 0, 255, 1, 37, 201, 120, 10};
    int phase_src[PHASES]    = '{0, 87, 0, 34, 0, 87, 0, 34};
    int phase_sink[PHASES]   = '{0, 0, 87, 34, 0, 0, 87, 34};

    mca_item_if   item_ch();
    mca_result_if res_ch();

    mouse_click_aggregator_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (res_ch)
    );

    click_packet_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_mon    (item_ch),
        .res_mon     (res_ch),
        .fail_cnt    (chk_fails),
        .pending_cnt (chk_pending),
        .packet_cnt  (chk_packets)
    );

    always #5 clk = ~clk;

    // packet side back-pressure
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_run <= 0;
        else if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    function automatic logic [15:0] pick_pos();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'h8000;
        if (r == 1)
            return 16'h7FFF;
        return 16'($urandom);
    endfunction

    task automatic add_item(input action_t act, input logic [7:0] b, input logic [15:0] st,
                            input logic [15:0] ex, input logic [15:0] ey,
                            input logic [15:0] nx, input logic [15:0] ny);
        cmd_t c;
        c.action  = act;
        c.buttons = b;
        c.stamp   = st;
        c.event_x = ex;
        c.event_y = ey;
        c.now_x   = nx;
        c.now_y   = ny;
        clock_now = st;
        if (act == ACT_BUTTON)
            held_btn = b;
        script.push_back(c);
    endtask

    task automatic add_button(input logic [7:0] b, input int dt);
        add_item(ACT_BUTTON, b, clock_now + 16'(dt), pick_pos(), pick_pos(), pick_pos(), pick_pos());
    endtask

    task automatic add_tick(input int dt);
        add_item(ACT_TICK, 8'($urandom), clock_now + 16'(dt),
                 pick_pos(), pick_pos(), pick_pos(), pick_pos());
    endtask

    // Mostly click groups with stamps inside the window, plus odd stamps and noise.
    task automatic gen_gesture();
        int         r;
        int         k;
        logic [7:0] b;
        r = $urandom_range(99);
        if (r < 45)
        begin
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++)
            begin
                b = 8'($urandom_range(1, 3));
                if ($urandom_range(4) == 0)
                    b = b | (8'($urandom) & 8'hFC);
                add_button(b, $urandom_range(0, 30));
                b = ($urandom_range(4) == 0) ? (8'($urandom) & 8'hFC) : 8'h00;
                add_button(b, $urandom_range(0, 30));
            end
            k = $urandom_range(0, 6);
            for (int i = 0; i < k; i++)
                add_tick($urandom_range(0, 80));
        end
        else if (r < 60)
        begin
            add_button(8'h01, $urandom_range(0, 20));
            add_button(8'h03, $urandom_range(0, 20));
            add_button(8'h02, $urandom_range(0, 20));
            add_button(8'h00, $urandom_range(0, 20));
        end
        else if (r < 75)
        begin
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++)
                add_tick($urandom_range(0, 150));
        end
        else if (r < 85)
        begin
            add_button(held_btn, $urandom_range(0, 40));
            add_button(held_btn, $urandom_range(0, 40));
        end
        else if (r < 92)
        begin
            b = 8'($urandom_range(0, 3));
            if ($urandom_range(1) == 0)
                add_button(b, 0 - int'($urandom_range(1, 50)));
            else
            begin
                clock_now = 16'($urandom);
                add_button(b, 0);
            end
        end
        else
        begin
            clock_now = 16'($urandom);
            if ($urandom_range(1) == 0)
                add_tick(0);
            else
                add_button(8'($urandom), 0);
        end
    endtask

    // Long click run that drives every counter into saturation, then expires.
    task automatic add_burst();
        for (int i = 0; i < 265; i++)
        begin
            add_button(8'h03, $urandom_range(0, 1));
            add_button(8'h00, $urandom_range(0, 1));
        end
        for (int i = 0; i < 3; i++)
            add_tick(4000);
    endtask

    task automatic send_item(input cmd_t c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.action  <= c.action;
        item_ch.buttons <= c.buttons;
        item_ch.stamp   <= c.stamp;
        item_ch.event_x <= c.event_x;
        item_ch.event_y <= c.event_y;
        item_ch.now_x   <= c.now_x;
        item_ch.now_y   <= c.now_y;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic flush_script();
        while (script.size() > 0)
            send_item(script.pop_front());
    endtask

    // Wait for every predicted packet, then let request-only work in the queue finish.
    // The first edge lets the checker's count take in the request accepted last.
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [7:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        int quota;
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= 8'd0;
        item_ch.valid   <= 1'b0;
        item_ch.action  <= 1'b0;
        item_ch.buttons <= 8'd0;
        item_ch.stamp   <= 16'd0;
        item_ch.event_x <= 16'd0;
        item_ch.event_y <= 16'd0;
        item_ch.now_x   <= 16'd0;
        item_ch.now_y   <= 16'd0;
        clock_now = 16'd0;
        held_btn  = 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window of zero: a press arms nothing, the release emits
        add_item(ACT_BUTTON, 8'h01, 16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        add_item(ACT_BUTTON, 8'h01, 16'h0001, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        add_item(ACT_BUTTON, 8'h00, 16'h0002, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        add_item(ACT_BUTTON, 8'hFF, 16'hFFFF, 16'h1234, 16'h5678, 16'h0000, 16'h0000);
        add_item(ACT_BUTTON, 8'hFC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 4; i++)
            add_item(ACT_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        flush_script();

        // write above the clamp
        write_window(8'hFF);
        add_item(ACT_BUTTON, 8'h03, 16'hFFF0, 16'h0100, 16'h0200, 16'h0300, 16'h0400);
        add_item(ACT_BUTTON, 8'h00, 16'h0005, 16'h0000, 16'h0000, 16'h0001, 16'h0002);
        add_item(ACT_BUTTON, 8'h01, 16'h0010, 16'h0000, 16'h0000, 16'h0003, 16'h0004);
        // stamp going backwards lengthens the countdown
        add_item(ACT_BUTTON, 8'h02, 16'h0008, 16'h0000, 16'h0000, 16'h0005, 16'h0006);
        add_item(ACT_TICK, 8'h00, 16'h0100, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
        add_item(ACT_TICK, 8'h00, 16'h0100, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
        add_item(ACT_BUTTON, 8'h00, 16'h0101, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
        // expiry and an empty packet from the same request
        add_item(ACT_BUTTON, 8'h01, 16'h0200, 16'hABCD, 16'h00FF, 16'h0000, 16'h0000);
        add_item(ACT_BUTTON, 8'h00, 16'h4000, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0);
        add_item(ACT_BUTTON, 8'h02, 16'h4001, 16'h0042, 16'hFF42, 16'h0000, 16'h0000);
        add_item(ACT_TICK, 8'h00, 16'h4001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_item(ACT_TICK, 8'h00, 16'h4001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_item(ACT_BUTTON, 8'h00, 16'h4002, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_item(ACT_TICK, 8'h00, 16'hC000, 16'h0000, 16'h0000, 16'h1357, 16'h2468);
        add_item(ACT_TICK, 8'h00, 16'hC000, 16'h0000, 16'h0000, 16'h9BDF, 16'hACE0);
        flush_script();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_window(8'(phase_window[ph]));
            src_idle_pct    = phase_src[ph];
            sink_stall_pct <= phase_sink[ph];
            if (ph == 2)
            begin
                add_burst();
                flush_script();
            end
            quota = sent + PHASE_REQUESTS;
            while (sent < quota)
            begin
                gen_gesture();
                flush_script();
            end
        end
        drain();

        $display("tb_top: %0d requests sent across %0d window settings and four idle patterns",
                 sent, PHASES + 1);
        $display("tb_top: %0d click packets compared, %0d mismatches", chk_packets, chk_fails);
        if (chk_fails == 0 && chk_pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
